FILE: design/ntt_negacyclic_poly_multiply_defines.svh
// Assertion macros for the negacyclic NTT multiplier checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef NTT_NEGACYCLIC_POLY_MULTIPLY_DEFINES_SVH
`define NTT_NEGACYCLIC_POLY_MULTIPLY_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define NTT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre.
`define NTT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/ntt_pkg.sv
// Shared types, constants and modular helpers for the negacyclic NTT multiplier.
// No dependencies; every design module imports this package.
package ntt_pkg;

    localparam int POLY_DEGREE = 512;
    localparam int LOG_N       = 9;
    localparam int COEF_W      = 14;

    localparam logic [13:0] MODQ     = 14'd12289;
    localparam logic [15:0] QNEG_INV = 16'd12287;
    localparam logic [13:0] MONT_R   = 14'd4091;
    localparam logic [13:0] MONT_R2  = 14'd10952;
    localparam logic [13:0] SCALE_N  = 14'd128;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [LOG_N-1:0]  addr_t;
    typedef logic [COEF_W-1:0] tw_table_t [POLY_DEGREE];

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_MULTIPLY = 2'd1,
        ACT_READ     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_RD,
        ST_MUL,
        ST_W1,
        ST_W2,
        ST_WA,
        ST_WB
    } seq_state_t;

    typedef enum logic [2:0] {
        PH_PRE,
        PH_FWD_SIG,
        PH_FWD_KEY,
        PH_POINT,
        PH_INV,
        PH_SCALE
    } phase_t;

    // Reduce a value below 2q into [0,q).
    function automatic coef_t cond_sub(logic [14:0] v);
        logic [14:0] d;
        d = v - {1'b0, MODQ};
        return (v >= {1'b0, MODQ}) ? d[13:0] : v[13:0];
    endfunction

    function automatic coef_t mod_add(coef_t a, coef_t b);
        return cond_sub({1'b0, a} + {1'b0, b});
    endfunction

    function automatic coef_t mod_sub(coef_t a, coef_t b);
        logic [14:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + {1'b0, MODQ} - {1'b0, b};
        end
        return d[13:0];
    endfunction

    // Elaboration-time helpers for the twiddle tables.
    function automatic int unsigned pmul(int unsigned a, int unsigned b);
        return (a * b) % 12289;
    endfunction

    function automatic int unsigned ppow(int unsigned b, int unsigned e);
        int unsigned r;
        int unsigned bb;
        int unsigned ee;
        r  = 1;
        bb = b;
        ee = e;
        while (ee != 0) begin
            if (ee[0]) r = pmul(r, bb);
            bb = pmul(bb, bb);
            ee = ee >> 1;
        end
        return r;
    endfunction

    function automatic int unsigned bitrev9(int unsigned k);
        int unsigned r;
        r = 0;
        for (int i = 0; i < LOG_N; i++) begin
            r = (r << 1) | ((k >> i) & 1);
        end
        return r;
    endfunction

    // Bit-reversed powers of psi (or psi^-1), in Montgomery form.
    function automatic tw_table_t build_twiddles(bit inverse);
        tw_table_t   tab;
        int unsigned psi;
        int unsigned c;
        int unsigned base;
        int unsigned val;
        psi = 0;
        for (int unsigned g = 2; g < 12289; g++) begin
            c = ppow(g, 12);
            if (psi == 0 && ppow(c, 512) == 12288) psi = c;
        end
        base = inverse ? ppow(psi, 1023) : psi;
        for (int k = 0; k < POLY_DEGREE; k++) begin
            val    = pmul(ppow(base, bitrev9(k)), 4091);
            tab[k] = val[COEF_W-1:0];
        end
        return tab;
    endfunction

endpackage

FILE: design/ntt_poly_ram.sv
// Coefficient store: one write port, two registered read ports.
// Depends on ntt_pkg for coefficient and address types.
module ntt_poly_ram
    import ntt_pkg::*;
(
    input  logic  aclk,
    input  logic  we,
    input  addr_t waddr,
    input  coef_t wdata,
    input  logic  re,
    input  addr_t raddr_a,
    input  addr_t raddr_b,
    output coef_t rdata_a,
    output coef_t rdata_b
);

    coef_t mem [POLY_DEGREE];

    // Write one word, read two words, data held until the next read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: design/ntt_twiddle_rom.sv
// Forward and inverse twiddle tables with a registered read.
// Depends on ntt_pkg, which builds the tables at elaboration.
module ntt_twiddle_rom
    import ntt_pkg::*;
(
    input  logic  aclk,
    input  logic  re,
    input  logic  inv_sel,
    input  addr_t addr,
    output coef_t rdata
);

    localparam tw_table_t FWD_TABLE = build_twiddles(1'b0);
    localparam tw_table_t INV_TABLE = build_twiddles(1'b1);

    // Fetch the twiddle for the current butterfly.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= inv_sel ? INV_TABLE[addr] : FWD_TABLE[addr];
        end
    end

endmodule

FILE: design/ntt_mont_mul.sv
// Three-stage Montgomery multiplier, R = 2^16, result fully reduced to [0,q).
// Depends on ntt_pkg for the modulus constants.
module ntt_mont_mul
    import ntt_pkg::*;
(
    input  logic  aclk,
    input  coef_t x,
    input  coef_t y,
    output coef_t result
);

    logic [27:0] z_reg;
    logic [27:0] z2_reg;
    logic [15:0] k_reg;
    coef_t       res_reg;
    logic [31:0] k_full;
    logic [30:0] sum;
    logic [14:0] s;

    // Form k = (z mod R) * (-q^-1) mod R and the shifted sum.
    always_comb begin
        k_full = {16'd0, z_reg[15:0]} * {16'd0, QNEG_INV};
        sum    = {3'd0, z2_reg} + ({15'd0, k_reg} * {17'd0, MODQ});
        s      = sum[30:16];
    end

    // Advance the pipeline every cycle.
    always_ff @(posedge aclk) begin
        z_reg   <= {14'd0, x} * {14'd0, y};
        z2_reg  <= z_reg;
        k_reg   <= k_full[15:0];
        res_reg <= cond_sub(s);
    end

    assign result = res_reg;

endmodule

FILE: design/ntt_negacyclic_poly_multiply.sv
// Top level of the negacyclic NTT multiplier: handshakes, sequencer, address generation.
// Depends on ntt_pkg, ntt_poly_ram, ntt_twiddle_rom and ntt_mont_mul.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_action, s_index, s_sig_coef, s_key_coef
//  m_      | out       | m_valid/m_ready  | m_product_coef, m_done_res
//
// Load, read and unused words pass through ST_RESP, which loads the result register once
// the output slot is free. A multiply runs each butterfly through ST_RD, ST_MUL, ST_W1,
// ST_W2, ST_WA and ST_WB, and each single-point step through ST_RD to ST_WA, on the one
// shared three-stage Montgomery unit; one write port per memory splits ST_WA and ST_WB.
// Reset clears only control state; memories hold whatever was loaded.
// A result waiting on m_ready does not block accepting the next input word.
module ntt_negacyclic_poly_multiply
    import ntt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [8:0]  s_index,
    input  logic [13:0] s_sig_coef,
    input  logic [13:0] s_key_coef,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_product_coef,
    output logic        m_done_res
);

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] stage_reg, stage_next;
    logic [8:0] cnt_reg, cnt_next;
    action_t    act_reg, act_next;
    logic       m_valid_reg, m_valid_next;
    coef_t      prod_reg;
    logic       done_reg;

    logic  accept;
    logic  out_load;
    logic  two_point;
    logic  step_last;
    addr_t addr_a, addr_b, tw_addr;
    addr_t raddr_a, raddr_b, waddr;
    logic  ram_re;
    logic  fst_we, sec_we;
    coef_t fst_wdata, sec_wdata;
    coef_t fst_a, fst_b, sec_a, sec_b;
    coef_t tw_data;
    coef_t mm_x, mm_y, mm_res;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign two_point = (phase_reg == PH_FWD_SIG) || (phase_reg == PH_FWD_KEY) ||
                       (phase_reg == PH_INV);

    // Generate butterfly and twiddle addresses from stage and counter.
    always_comb begin
        logic [3:0] sh;
        logic [8:0] bi, tval, i_idx, jj, base_a;
        bi = {1'b0, cnt_reg[7:0]};
        sh = (phase_reg == PH_INV) ? stage_reg : (4'd8 - stage_reg);
        tval   = 9'd1 << sh;
        i_idx  = bi >> sh;
        jj     = bi & (tval - 9'd1);
        base_a = (i_idx << (sh + 4'd1)) | jj;
        if (two_point) begin
            addr_a = base_a;
            addr_b = base_a + tval;
        end else begin
            addr_a = cnt_reg;
            addr_b = cnt_reg;
        end
        if (phase_reg == PH_INV) begin
            tw_addr = (9'd256 >> stage_reg) + i_idx;
        end else begin
            tw_addr = (9'd1 << stage_reg) + i_idx;
        end
    end

    assign step_last = two_point ?
        (cnt_reg[7:0] == 8'hFF && stage_reg == 4'(LOG_N - 1)) : (cnt_reg == 9'h1FF);

    // Select multiplier operands for the current phase.
    always_comb begin
        case (phase_reg)
            PH_PRE: begin
                mm_x = sec_a;
                mm_y = MONT_R2;
            end
            PH_FWD_SIG: begin
                mm_x = fst_b;
                mm_y = tw_data;
            end
            PH_FWD_KEY: begin
                mm_x = sec_b;
                mm_y = tw_data;
            end
            PH_POINT: begin
                mm_x = fst_a;
                mm_y = sec_a;
            end
            PH_INV: begin
                mm_x = mod_sub(fst_a, fst_b);
                mm_y = tw_data;
            end
            default: begin
                mm_x = fst_a;
                mm_y = SCALE_N;
            end
        endcase
    end

    // Sequencer: next state, memory control and output load.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        out_load   = 1'b0;
        ram_re     = 1'b0;
        raddr_a    = addr_a;
        raddr_b    = addr_b;
        waddr      = addr_a;
        fst_we     = 1'b0;
        sec_we     = 1'b0;
        fst_wdata  = mm_res;
        sec_wdata  = mm_res;
        case (state_reg)
            ST_IDLE: begin
                raddr_a = s_index;
                raddr_b = s_index;
                waddr   = s_index;
                fst_wdata = cond_sub({1'b0, s_sig_coef});
                sec_wdata = cond_sub({1'b0, s_key_coef});
                if (accept) begin
                    act_next = action_t'(s_action);
                    case (action_t'(s_action))
                        ACT_LOAD: begin
                            fst_we = 1'b1;
                            sec_we = 1'b1;
                            state_next = ST_RESP;
                        end
                        ACT_READ: begin
                            ram_re = 1'b1;
                            state_next = ST_RESP;
                        end
                        ACT_MULTIPLY: begin
                            phase_next = PH_PRE;
                            stage_next = 4'd0;
                            cnt_next   = 9'd0;
                            state_next = ST_RD;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_W1;
            ST_W1:  state_next = ST_W2;
            ST_W2:  state_next = ST_WA;
            ST_WA, ST_WB: begin
                // Write the upper or lower butterfly output, or the single result.
                if (state_reg == ST_WB) waddr = addr_b;
                case (phase_reg)
                    PH_PRE: sec_we = 1'b1;
                    PH_FWD_SIG: begin
                        fst_we    = 1'b1;
                        fst_wdata = (state_reg == ST_WA) ? mod_add(fst_a, mm_res)
                                                         : mod_sub(fst_a, mm_res);
                    end
                    PH_FWD_KEY: begin
                        sec_we    = 1'b1;
                        sec_wdata = (state_reg == ST_WA) ? mod_add(sec_a, mm_res)
                                                         : mod_sub(sec_a, mm_res);
                    end
                    PH_INV: begin
                        fst_we    = 1'b1;
                        fst_wdata = (state_reg == ST_WA) ? mod_add(fst_a, fst_b) : mm_res;
                    end
                    default: fst_we = 1'b1;
                endcase
                if (state_reg == ST_WA && two_point) begin
                    state_next = ST_WB;
                end else begin
                    state_next = ST_RD;
                    cnt_next   = cnt_reg + 9'd1;
                    if (two_point && cnt_reg[7:0] == 8'hFF) begin
                        cnt_next   = 9'd0;
                        stage_next = stage_reg + 4'd1;
                    end
                    if (step_last) begin
                        cnt_next   = 9'd0;
                        stage_next = 4'd0;
                        case (phase_reg)
                            PH_PRE:     phase_next = PH_FWD_SIG;
                            PH_FWD_SIG: phase_next = PH_FWD_KEY;
                            PH_FWD_KEY: phase_next = PH_POINT;
                            PH_POINT:   phase_next = PH_INV;
                            PH_INV:     phase_next = PH_SCALE;
                            default:    state_next = ST_RESP;
                        endcase
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Hold control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_PRE;
            stage_reg   <= 4'd0;
            cnt_reg     <= 9'd0;
            act_reg     <= ACT_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            cnt_reg     <= cnt_next;
            act_reg     <= act_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result word.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            prod_reg <= (act_reg == ACT_READ) ? fst_a : '0;
            done_reg <= (act_reg == ACT_MULTIPLY);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_product_coef = prod_reg;
    assign m_done_res     = done_reg;

    ntt_poly_ram u_first_ram (
        .aclk    (aclk),
        .we      (fst_we),
        .waddr   (waddr),
        .wdata   (fst_wdata),
        .re      (ram_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (fst_a),
        .rdata_b (fst_b)
    );

    ntt_poly_ram u_second_ram (
        .aclk    (aclk),
        .we      (sec_we),
        .waddr   (waddr),
        .wdata   (sec_wdata),
        .re      (ram_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (sec_a),
        .rdata_b (sec_b)
    );

    ntt_twiddle_rom u_twiddle_rom (
        .aclk    (aclk),
        .re      (state_reg == ST_RD),
        .inv_sel (phase_reg == PH_INV),
        .addr    (tw_addr),
        .rdata   (tw_data)
    );

    ntt_mont_mul u_mont_mul (
        .aclk   (aclk),
        .x      (mm_x),
        .y      (mm_y),
        .result (mm_res)
    );

endmodule

FILE: design/ntt_checker.sv
// Port-level checker for the negacyclic NTT multiplier, bound to the top level.
// Depends on ntt_pkg and the assertion macros header.
`include "ntt_negacyclic_poly_multiply_defines.svh"

module ntt_checker
    import ntt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [13:0] m_product_coef,
    input logic        m_done_res
);

    // A stalled result word holds.
    `NTT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_product_coef) && $stable(m_done_res), "result word changed while stalled")

    // A multiply completion carries no coefficient.
    `NTT_ASSERT_NOW(a_done_zero, m_valid && m_done_res, m_product_coef == 14'd0, "done word with nonzero coefficient")

    // Every delivered coefficient is reduced.
    `NTT_ASSERT_NOW(a_reduced, m_valid, m_product_coef < MODQ, "coefficient not reduced")

    // The block goes busy after taking a multiply command.
    `NTT_ASSERT_NEXT(a_busy, s_valid && s_ready && s_action == ACT_MULTIPLY, !s_ready, "ready right after multiply")

endmodule

bind ntt_negacyclic_poly_multiply ntt_checker u_ntt_checker (.*);

FILE: test/tb.sv
// Testbench for the negacyclic NTT polynomial multiplier (q = 12289, N = 512).
// Drives load, multiply and read words, predicts products with an own NTT model.
// Depends on ntt_pkg and ntt_negacyclic_poly_multiply.
module tb;
    import ntt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = 512;
    localparam int Q = 12289;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [13:0] product_coef;
        logic        done_res;
    } result_t;

    // Scoreboard: own polynomial state and queue of pending results.
    class product_scoreboard;
        int unsigned sig_mem [N];
        int unsigned key_mem [N];
        int unsigned fwd_tw [N];
        int unsigned inv_tw [N];
        result_t pending [$];
        int errors;

        function int unsigned red(int unsigned v);
            return (v >= Q) ? v - Q : v;
        endfunction

        function int unsigned msub(int unsigned a, int unsigned b);
            return (a >= b) ? a - b : a + Q - b;
        endfunction

        function int unsigned mmul(int unsigned x, int unsigned y);
            int unsigned z;
            int unsigned k;
            z = x * y;
            k = ((z & 32'hFFFF) * 12287) & 32'hFFFF;
            return red((z + k * Q) >> 16);
        endfunction

        function int unsigned pw(int unsigned b, int unsigned e);
            int unsigned r;
            r = 1;
            while (e != 0) begin
                if (e & 1) r = (r * b) % Q;
                b = (b * b) % Q;
                e = e >> 1;
            end
            return r;
        endfunction

        function new();
            int unsigned psi;
            int unsigned c;
            int unsigned e;
            psi = 0;
            for (int unsigned g = 2; g < Q && psi == 0; g++) begin
                c = pw(g, 12);
                if (pw(c, 512) == Q - 1) psi = c;
            end
            for (int k = 0; k < N; k++) begin
                e = 0;
                for (int i = 0; i < 9; i++) e = (e << 1) | ((k >> i) & 1);
                fwd_tw[k] = (pw(psi, e) * 4091) % Q;
                inv_tw[k] = (pw(pw(psi, 1023), e) * 4091) % Q;
                sig_mem[k] = 0;
                key_mem[k] = 0;
            end
            errors = 0;
        endfunction

        function void forward(ref int unsigned a [N]);
            int unsigned t;
            int unsigned u;
            int unsigned v;
            t = N;
            for (int m = 1; m < N; m = m << 1) begin
                t = t >> 1;
                for (int i = 0; i < m; i++) begin
                    for (int j = 2 * i * t; j < 2 * i * t + t; j++) begin
                        u = a[j];
                        v = mmul(a[j + t], fwd_tw[m + i]);
                        a[j] = red(u + v);
                        a[j + t] = msub(u, v);
                    end
                end
            end
        endfunction

        function void inverse(ref int unsigned a [N]);
            int unsigned t;
            int unsigned u;
            int unsigned v;
            t = 1;
            for (int m = N; m > 1; m = m >> 1) begin
                for (int i = 0; i < m / 2; i++) begin
                    for (int j = 2 * i * t; j < 2 * i * t + t; j++) begin
                        u = a[j];
                        v = a[j + t];
                        a[j] = red(u + v);
                        a[j + t] = mmul(msub(u, v), inv_tw[m / 2 + i]);
                    end
                end
                t = t << 1;
            end
            for (int j = 0; j < N; j++) a[j] = mmul(a[j], 128);
        endfunction

        // Note an accepted word and queue its result.
        function void note_word(action_t act, int unsigned idx, int unsigned sc,
                                int unsigned kc);
            result_t r;
            r = '0;
            case (act)
                ACT_LOAD: begin
                    sig_mem[idx] = red(sc);
                    key_mem[idx] = red(kc);
                end
                ACT_MULTIPLY: begin
                    for (int j = 0; j < N; j++) key_mem[j] = mmul(key_mem[j], 10952);
                    forward(sig_mem);
                    forward(key_mem);
                    for (int j = 0; j < N; j++) sig_mem[j] = mmul(sig_mem[j], key_mem[j]);
                    inverse(sig_mem);
                    r.done_res = 1'b1;
                end
                ACT_READ: r.product_coef = sig_mem[idx][13:0];
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // Check a result word against the oldest expectation.
        function void check_word(result_t got);
            result_t exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: coef exp %0d got %0d, done exp %0b got %0b",
                             exp_r.product_coef, got.product_coef,
                             exp_r.done_res, got.done_res);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [8:0]  s_index;
    logic [13:0] s_sig_coef;
    logic [13:0] s_key_coef;
    logic        m_valid;
    logic        m_ready;
    logic [13:0] m_product_coef;
    logic        m_done_res;

    product_scoreboard sb;
    int cycles;

    ntt_negacyclic_poly_multiply u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Count cycles and stop on a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word('{m_product_coef, m_done_res});
    end

    // Stall the result side at random, with stall-free stretches.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Send one word after a random gap and wait for its acceptance.
    task automatic send_word(action_t act, int idx, int sc, int kc);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_index    <= 9'(idx);
        s_sig_coef <= 14'(sc);
        s_key_coef <= 14'(kc);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(act, idx, sc, kc);
        @(negedge aclk);
    endtask

    task automatic load_all(int mode);
        int sc;
        int kc;
        for (int i = 0; i < N; i++) begin
            case (mode)
                0: begin sc = 0; kc = 0; end
                1: begin sc = 12288; kc = 12288; end
                default: begin
                    sc = ($urandom_range(0, 15) == 0) ? $urandom_range(12289, 16383)
                                                      : $urandom_range(0, 12288);
                    kc = ($urandom_range(0, 15) == 0) ? $urandom_range(12289, 16383)
                                                      : $urandom_range(0, 12288);
                end
            endcase
            send_word(ACT_LOAD, i, sc, kc);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int act;
        int idx;
        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_LOAD;
        s_index = '0;
        s_sig_coef = '0;
        s_key_coef = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: partial load and reads, unused action, out-of-range load.
        send_word(ACT_LOAD, 0, 16383, 16383);
        send_word(ACT_LOAD, 511, 12289, 0);
        send_word(ACT_READ, 0, 0, 0);
        send_word(ACT_READ, 511, 16383, 16383);
        send_word(ACT_NONE, 511, 16383, 16383);
        send_word(ACT_READ, 0, 0, 0);
        // One full random load, multiply, then the product in place.
        load_all(2);
        send_word(ACT_MULTIPLY, 511, 16383, 16383);
        send_word(ACT_READ, 0, 0, 0);
        send_word(ACT_READ, 511, 0, 0);
        send_word(ACT_MULTIPLY, 0, 0, 0);
        send_word(ACT_READ, 255, 0, 0);

        // Hold off until every result has come back.
        wait_drained();

        // Random: reads, reloads, unused words and an occasional multiply.
        for (int k = 0; k < 70; k++) begin
            act = $urandom_range(0, 9);
            idx = $urandom_range(0, 511);
            if (act < 6) act = ACT_READ;
            else if (act < 8) act = ACT_LOAD;
            else if (act < 9) act = ACT_NONE;
            else act = ($urandom_range(0, 3) == 0) ? ACT_MULTIPLY : ACT_READ;
            send_word(action_t'(act), idx, $urandom_range(0, 16383),
                      $urandom_range(0, 16383));
        end

        wait_drained();
        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

FILE: ntt_negacyclic_poly_multiply.f
+incdir+design
design/ntt_pkg.sv
design/ntt_poly_ram.sv
design/ntt_twiddle_rom.sv
design/ntt_mont_mul.sv
design/ntt_negacyclic_poly_multiply.sv
design/ntt_checker.sv
test/tb.sv
